// ===== rtl/bwhp_pkg.sv =====
// ----------------------------------------------------------------------------
// bwhp_pkg
// Shared constants and types of the Butterworth high-pass filter block.
// ----------------------------------------------------------------------------
package bwhp_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RATE_W          = 18;
	localparam int CUTOFF_W        = 17;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

	localparam logic [18:0] TWOPI_Q16 = 19'd411775;
	localparam logic [16:0] SQRT2_Q16 = 17'd92682;

	localparam int COEF_FRAC = 30;
	localparam int COEF_W    = 32;
	localparam int NUM_W     = 51;
	localparam int DEN_W     = 50;
	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [COEF_W-1:0] coef;
	} div_rsp_t;

endpackage

// ===== rtl/bwhp_div.sv =====
// ----------------------------------------------------------------------------
// bwhp_div
// Shift-subtract divider giving one saturated Q2.30 coefficient per request.
// ----------------------------------------------------------------------------
module bwhp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bwhp_pkg::div_req_t req,
	output bwhp_pkg::div_rsp_t rsp
);

	localparam int RW    = bwhp_pkg::DEN_W + 3;
	localparam int QW    = bwhp_pkg::COEF_W;
	localparam int CNT_W = $clog2(bwhp_pkg::DIV_STEPS);

	logic [RW-1:0]    r_q;
	logic [RW-1:0]    d_q;
	logic [QW-1:0]    q_q;
	logic             neg_q;
	logic             dzero_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW-1:0]            mag;
	logic [RW-1:0]            t;
	logic                     ge;
	logic signed [QW-1:0]     coef;

	always_comb begin
		if (req.num[bwhp_pkg::NUM_W-1]) begin
			mag = RW'(-req.num);
		end else begin
			mag = RW'(req.num);
		end
		t  = (cnt_q == '0) ? r_q : {r_q[RW-2:0], 1'b0};
		ge = (t >= d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q &&
				(cnt_q == CNT_W'(bwhp_pkg::DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bwhp_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q     <= mag;
			d_q     <= {2'b00, req.den, 1'b0};
			neg_q   <= req.num[bwhp_pkg::NUM_W-1];
			dzero_q <= (req.den == '0);
			q_q     <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (t - d_q) : t;
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (dzero_q) begin
			coef = '0;
		end else if (neg_q) begin
			coef = -$signed(q_q);
		end else if (q_q[QW-1]) begin
			coef = {1'b0, {(QW-1){1'b1}}};
		end else begin
			coef = $signed(q_q);
		end
	end

	assign rsp.done = done_q;
	assign rsp.coef = coef;

endmodule

// ===== rtl/butterworth_highpass2_variable_cutoff.sv =====
// ----------------------------------------------------------------------------
// butterworth_highpass2_variable_cutoff
// Second-order Butterworth high-pass biquad with per-sample cutoff.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         in_valid/in_stall    sample_in, cutoff_hz
// output    out        out_valid/out_stall  sample_out
// config    in         cfg_wr_en            cfg_wr_data (sample rate, Hz)
//
// A transaction runs from acceptance to the result through the multiplier
// steps for the coefficient terms (WC, WC2, FS, P, KH, KL), a denominator step,
// three divisions on the shared divider (start, 32 steps, done), one
// multiply-accumulate step per coefficient and an output step. The divisions
// dominate; a new transaction is accepted only once the block is idle again.
// Input is stalled from acceptance until the result is loaded into the output
// register; a stalled output holds the block in its last cycle.
// Reset clears the filter history and sets the rate to 48000 Hz.
// ----------------------------------------------------------------------------
module butterworth_highpass2_variable_cutoff #(
	parameter int SAMPLE_BITS = bwhp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bwhp_pkg::RATE_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  logic [bwhp_pkg::CUTOFF_W-1:0]       cutoff_hz,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_out
);

	localparam int HIST = SAMPLE_BITS + 8;
	localparam int VW   = SAMPLE_BITS + 2;
	localparam int MA   = bwhp_pkg::COEF_W + 1;
	localparam int MB   = (HIST + 1 > 26) ? HIST + 1 : 26;
	localparam int PW   = MA + MB;
	localparam int AW   = PW + 2;
	localparam int YW   = AW - bwhp_pkg::COEF_FRAC;
	localparam int NW   = bwhp_pkg::NUM_W;
	localparam int DW   = bwhp_pkg::DEN_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WC    = 4'd1;
	localparam logic [3:0] ST_WC2   = 4'd2;
	localparam logic [3:0] ST_FS    = 4'd3;
	localparam logic [3:0] ST_P     = 4'd4;
	localparam logic [3:0] ST_KH    = 4'd5;
	localparam logic [3:0] ST_KL    = 4'd6;
	localparam logic [3:0] ST_DEN   = 4'd7;
	localparam logic [3:0] ST_DSTART = 4'd8;
	localparam logic [3:0] ST_DWAIT = 4'd9;
	localparam logic [3:0] ST_MAC   = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0]                        state_q;
	logic [1:0]                        ci_q;
	logic [bwhp_pkg::RATE_W-1:0]       rate_q;
	logic signed [SAMPLE_BITS-1:0]     x_q;
	logic [bwhp_pkg::CUTOFF_W-1:0]     fc_q;
	logic signed [SAMPLE_BITS-1:0]     x1_q;
	logic signed [SAMPLE_BITS-1:0]     x2_q;
	logic signed [HIST-1:0]            y1_q;
	logic signed [HIST-1:0]            y2_q;
	logic [23:0]                       wc_q;
	logic [47:0]                       wc2_q;
	logic [45:0]                       fs4_q;
	logic [42:0]                       p_q;
	logic [38:0]                       kh_q;
	logic [47:0]                       k_q;
	logic [DW-1:0]                     den_q;
	logic signed [bwhp_pkg::COEF_W-1:0] c_q [3];
	logic signed [AW-1:0]              acc_q;
	logic                              out_valid_q;
	logic signed [SAMPLE_BITS-1:0]     sample_out_q;

	logic [18:0]              two_fs;
	logic signed [MA-1:0]     mul_a;
	logic signed [MB-1:0]     mul_b;
	logic signed [PW-1:0]     prod;
	logic [36:0]              wc_rnd;
	logic [60:0]              ksum;
	logic signed [VW-1:0]     v0;
	logic signed [NW-1:0]     num;
	logic signed [AW-1:0]     acc_rnd;
	logic signed [YW-1:0]     y;
	logic signed [HIST-1:0]   y_hist;
	logic signed [SAMPLE_BITS-1:0] y_out;
	logic                     out_free;
	bwhp_pkg::div_req_t       div_req;
	bwhp_pkg::div_rsp_t       div_rsp;

	assign two_fs = {rate_q, 1'b0};

	assign v0 = VW'(x_q) - (VW'(x1_q) <<< 1) + VW'(x2_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_WC: begin
				mul_a = {{(MA-bwhp_pkg::CUTOFF_W){1'b0}}, fc_q};
				mul_b = {{(MB-19){1'b0}}, bwhp_pkg::TWOPI_Q16};
			end
			ST_WC2: begin
				mul_a = {{(MA-24){1'b0}}, wc_q};
				mul_b = {{(MB-24){1'b0}}, wc_q};
			end
			ST_FS: begin
				mul_a = {{(MA-19){1'b0}}, two_fs};
				mul_b = {{(MB-19){1'b0}}, two_fs};
			end
			ST_P: begin
				mul_a = {{(MA-19){1'b0}}, two_fs};
				mul_b = {{(MB-24){1'b0}}, wc_q};
			end
			ST_KH: begin
				mul_a = {{(MA-22){1'b0}}, p_q[42:21]};
				mul_b = {{(MB-17){1'b0}}, bwhp_pkg::SQRT2_Q16};
			end
			ST_KL: begin
				mul_a = {{(MA-21){1'b0}}, p_q[20:0]};
				mul_b = {{(MB-17){1'b0}}, bwhp_pkg::SQRT2_Q16};
			end
			ST_MAC: begin
				mul_a = MA'(c_q[ci_q]);
				case (ci_q)
					2'd0:    mul_b = MB'(v0);
					2'd1:    mul_b = MB'(y1_q);
					default: mul_b = MB'(y2_q);
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign wc_rnd = prod[36:0] + 37'd2048;
	assign ksum   = {kh_q, 21'd0} + 61'(prod[37:0]) + 61'd2048;

	always_comb begin
		case (ci_q)
			2'd0:    num = NW'({1'b0, fs4_q});
			2'd1:    num = (NW'({1'b0, fs4_q}) <<< 1) - (NW'({1'b0, wc2_q}) <<< 1);
			default: num = NW'({1'b0, k_q}) - NW'({1'b0, fs4_q}) - NW'({1'b0, wc2_q});
		endcase
	end

	assign div_req.start = (state_q == ST_DSTART);
	assign div_req.num   = num;
	assign div_req.den   = den_q;

	bwhp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign acc_rnd = acc_q + (AW'(1) <<< (bwhp_pkg::COEF_FRAC - 1));
	assign y       = acc_rnd[AW-1:bwhp_pkg::COEF_FRAC];

	always_comb begin
		if (y[YW-1:HIST-1] == '0 || y[YW-1:HIST-1] == '1) begin
			y_hist = y[HIST-1:0];
		end else if (y[YW-1]) begin
			y_hist = {1'b1, {(HIST-1){1'b0}}};
		end else begin
			y_hist = {1'b0, {(HIST-1){1'b1}}};
		end
		if (y[YW-1:SAMPLE_BITS-1] == '0 || y[YW-1:SAMPLE_BITS-1] == '1) begin
			y_out = y[SAMPLE_BITS-1:0];
		end else if (y[YW-1]) begin
			y_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ci_q        <= '0;
			rate_q      <= bwhp_pkg::RATE_RESET;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WC;
					end
				end
				ST_WC:  state_q <= ST_WC2;
				ST_WC2: state_q <= ST_FS;
				ST_FS:  state_q <= ST_P;
				ST_P:   state_q <= ST_KH;
				ST_KH:  state_q <= ST_KL;
				ST_KL:  state_q <= ST_DEN;
				ST_DEN: begin
					ci_q    <= '0;
					state_q <= ST_DSTART;
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done) begin
						if (ci_q == 2'd2) begin
							ci_q    <= '0;
							state_q <= ST_MAC;
						end else begin
							ci_q    <= ci_q + 1'b1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_MAC: begin
					if (ci_q == 2'd2) begin
						ci_q    <= '0;
						state_q <= ST_FIN;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						x2_q        <= x1_q;
						x1_q        <= x_q;
						y2_q        <= y1_q;
						y1_q        <= y_hist;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q  <= sample_in;
				fc_q <= cutoff_hz;
			end
			ST_WC:  wc_q  <= wc_rnd[35:12];
			ST_WC2: wc2_q <= prod[47:0];
			ST_FS:  fs4_q <= {prod[37:0], 8'd0};
			ST_P:   p_q   <= prod[42:0];
			ST_KH:  kh_q  <= prod[38:0];
			ST_KL:  k_q   <= ksum[59:12];
			ST_DEN: den_q <= DW'(fs4_q) + DW'(k_q) + DW'(wc2_q);
			ST_DWAIT: begin
				if (div_rsp.done) begin
					c_q[ci_q] <= div_rsp.coef;
				end
				acc_q <= '0;
			end
			ST_MAC: acc_q <= acc_q + AW'(prod);
			ST_FIN: begin
				if (out_free) begin
					sample_out_q <= y_out;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_WC))
		else $error("accepted transaction did not start the sequencer");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result appeared outside the final step");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DWAIT))
		else $error("divider finished while not awaited");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> in_stall)
		else $error("input open during accumulation");

endmodule

// ===== test/bwhp_checker.sv =====
// ----------------------------------------------------------------------------
// bwhp_checker
// Watches the filter's channels, predicts each output and compares it.
// ----------------------------------------------------------------------------
// Tracks the sample-rate register from the configuration port, keeps its own
// copy of the biquad history and, for every accepted input transaction, works
// out the fixed-point high-pass output. Output transactions are compared in
// order against the queue of predicted samples.
// ----------------------------------------------------------------------------
module bwhp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bwhp_pkg::RATE_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [15:0]            sample_in,
	input  logic [bwhp_pkg::CUTOFF_W-1:0] cutoff_hz,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [15:0]            sample_out,
	output int                            pending,
	output int                            errors,
	output int                            outputs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	logic [bwhp_pkg::RATE_W-1:0] rate_hz;
	wide_t                       x1, x2, y1, y2;
	logic signed [15:0]          expected_samples[$];

	function automatic wide_t ratio_q30(wide_t num, wide_t den);
		logic [127:0] mag;
		logic [127:0] q;
		if (den == 0) begin
			return 0;
		end
		mag = (num < 0) ? -num : num;
		q = (mag << bwhp_pkg::COEF_FRAC) / den;
		if (num < 0) begin
			return (q > (128'd1 << 31)) ? -(wide_t'(1) <<< 31) : -wide_t'(q);
		end
		return (q > ((128'd1 << 31) - 1)) ? (wide_t'(1) <<< 31) - 1 : wide_t'(q);
	endfunction

	function automatic wide_t clamp(wide_t v, int bits);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic logic signed [15:0] filter_sample(logic signed [15:0] x, logic [16:0] fc);
		wide_t fcw, two_fs, wc, wc2, fs4, kk, den, cb, ca1, ca2, acc, y;
		fcw = fc;
		two_fs = rate_hz;
		two_fs = two_fs * 2;
		wc = (fcw * bwhp_pkg::TWOPI_Q16 + 2048) >> 12;
		wc2 = wc * wc;
		fs4 = (two_fs * two_fs) << 8;
		kk = (two_fs * wc * bwhp_pkg::SQRT2_Q16 + 2048) >> 12;
		den = fs4 + kk + wc2;
		cb = ratio_q30(fs4, den);
		ca1 = ratio_q30(2 * fs4 - 2 * wc2, den);
		ca2 = ratio_q30(kk - fs4 - wc2, den);
		acc = cb * (wide_t'(x) - 2 * x1 + x2) + ca1 * y1 + ca2 * y2 + (wide_t'(1) <<< 29);
		y = acc >>> bwhp_pkg::COEF_FRAC;
		x2 = x1;
		x1 = x;
		y2 = y1;
		y1 = clamp(y, 24);
		return 16'(clamp(y, 16));
	endfunction

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			rate_hz = bwhp_pkg::RATE_RESET;
			x1 = 0;
			x2 = 0;
			y1 = 0;
			y2 = 0;
			expected_samples.delete();
		end else begin
			if (cfg_wr_en) begin
				rate_hz = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				expected_samples.push_back(filter_sample(sample_in, cutoff_hz));
			end
			if (out_valid && !out_stall) begin
				outputs_seen++;
				if (expected_samples.size() == 0) begin
					errors++;
					$display("%0t: unexpected output transaction, actual %0d", $time, sample_out);
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						errors++;
						$display("%0t: sample_out mismatch, expected %0d, actual %0d",
							$time, want, sample_out);
					end
				end
			end
		end
		pending = expected_samples.size();
	end

endmodule

// ===== test/butterworth_highpass2_variable_cutoff_tb.sv =====
// ----------------------------------------------------------------------------
// butterworth_highpass2_variable_cutoff_tb
// Stimulus and verdict for the variable-cutoff Butterworth high-pass filter.
// ----------------------------------------------------------------------------
// Runs directed extreme samples and cutoffs, then random audio at several
// sample rates including zero and the register maximum, under changing
// sender and receiver idle patterns, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module butterworth_highpass2_variable_cutoff_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [bwhp_pkg::RATE_W-1:0]   cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [15:0]            sample_in = '0;
	logic [bwhp_pkg::CUTOFF_W-1:0] cutoff_hz = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [15:0]            sample_out;

	int pending, errors, outputs_seen;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_on = 1'b0;
	int sent = 0;
	event hold_go;

	always #4 clk = ~clk;

	butterworth_highpass2_variable_cutoff u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .cutoff_hz(cutoff_hz),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out)
	);

	bwhp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .cutoff_hz(cutoff_hz),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.pending(pending), .errors(errors), .outputs_seen(outputs_seen)
	);

	// hold off the output each time hold_go fires
	always begin
		@(hold_go);
		hold_on <= 1'b1;
		repeat (600) @(negedge clk);
		hold_on <= 1'b0;
	end

	always @(negedge clk) begin
		if (hold_on) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// call at a falling edge; returns at a falling edge
	task automatic push_sample(logic signed [15:0] s, logic [16:0] fc);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		cutoff_hz <= fc;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic set_rate(logic [bwhp_pkg::RATE_W-1:0] r);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [16:0] pick_cutoff();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return 17'($urandom_range(20, 24000));
		end
		if (r < 85) begin
			return 17'($urandom_range(0, 96000));
		end
		return 17'($urandom_range(0, 131071));
	endfunction

	function automatic logic signed [15:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 5) begin
			return 16'sh7fff;
		end
		if (r < 10) begin
			return 16'sh8000;
		end
		return 16'($urandom);
	endfunction

	initial begin
		logic [bwhp_pkg::RATE_W-1:0] rates[6];
		logic [16:0] fc;
		rates = '{18'd48000, 18'd8000, 18'd192000, 18'd0, 18'd262143, 18'd44100};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_sample(16'sh7fff, 17'd0);
		push_sample(16'sh8000, 17'd0);
		push_sample(16'sh7fff, 17'd0);
		push_sample(16'sh7fff, 17'd96000);
		push_sample(16'sh8000, 17'd131071);
		push_sample(16'sh7fff, 17'd131071);
		push_sample(16'sh0000, 17'd1);
		push_sample(16'sh8000, 17'd24000);
		push_sample(16'sh7fff, 17'd24000);
		push_sample(16'sh8000, 17'd30000);
		push_sample(16'sh7fff, 17'd1000);
		push_sample(16'sh8000, 17'd1000);
		push_sample(16'sh0001, 17'd65536);
		push_sample(16'shffff, 17'd20);

		// long output hold-off while the sender keeps offering
		-> hold_go;
		repeat (10) push_sample(pick_sample(), pick_cutoff());
		drain();

		for (int p = 0; p < 6; p++) begin
			set_rate(rates[p]);
			if (rates[p] == 0) begin
				push_sample(16'sh7fff, 17'd0);
				push_sample(16'sh8000, 17'd5);
			end
			for (int m = 0; m < 4; m++) begin
				tx_idle_pct = (m == 1) ? 86 : (m == 3) ? 38 : 0;
				rx_stall_pct = (m == 2) ? 86 : (m == 3) ? 38 : 0;
				fc = pick_cutoff();
				for (int i = 0; i < 65; i++) begin
					if ($urandom_range(9) == 0) begin
						fc = pick_cutoff();
					end
					push_sample(pick_sample(), fc);
				end
			end
			tx_idle_pct = 0;
			rx_stall_pct = 0;
		end
		set_rate(18'd48000);
		repeat (20) push_sample(pick_sample(), pick_cutoff());

		drain();
		$display("Covered %0d input transactions and %0d outputs over six sample rates,",
			sent, outputs_seen);
		$display("including zero rate, maximum rate, extreme cutoffs and long stalls.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bwhp_pkg.sv
rtl/bwhp_div.sv
rtl/butterworth_highpass2_variable_cutoff.sv
test/bwhp_checker.sv
test/butterworth_highpass2_variable_cutoff_tb.sv
